// ----- sv/aarm_pkg.sv -----
// ---------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants of the axis-angle rotation matrix core: fixed
// point formats, the CORDIC arctangent table and the per-cell step control.
// ---------------------------------------------------------------------------
package aarm_pkg;

   // internal unit vectors, sine and cosine are Q2.30
   localparam int QBITS  = 30;
   // CORDIC x, y, z datapath width
   localparam int CORD_W = 34;
   // square root remainder and root width
   localparam int ROOT_W = 64;
   // normalized axis magnitude width
   localparam int NMAG_W = 30;
   // dividend (magnitude in Q2.30 plus rounding) and divisor widths
   localparam int NUM_W  = 61;
   localparam int DVS_W  = 31;
   // number of square root and divider cells
   localparam int SQRT_CELLS = 32;
   localparam int DIV_CELLS  = 31;
   // output element width
   localparam int ELEM_W = 18;

   // CORDIC gain compensation, 0.6072529350 in Q2.30
   localparam logic signed [CORD_W-1:0] CORDIC_K = 34'sd652032874;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // control handed to every cell of the chain
   typedef struct packed {
      logic en;    // the whole chain advances this cycle
      logic vld;   // the word entering the cell carries an item
   } aarm_step_type;

endpackage

// ----- sv/axis_angle_rotation_matrix_core.sv -----
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// Builds the 4x4 homogeneous rotation matrix of an axis and an angle
// (Rodrigues) and streams it out one row per transaction.
// ---------------------------------------------------------------------------
// Usage:
//   req_* takes one transaction per matrix: axis x, y, z and a binary angle
//   (a full turn is 65536). rsp_* returns four transactions per matrix, rows
//   0 to 3 in order; tlast marks row 3 and tuser carries the row index and
//   the degenerate flag (zero axis, identity output).
//   The datapath is a chain of cells: CORDIC_STAGES CORDIC cells, four
//   normalization stages, 32 square root cells, 31 divider cells and five
//   product and rounding stages. The single result channel carries four
//   rows per matrix; the chain holds many matrices in flight.
//   Reset empties the chain and the output register. While the output
//   register holds a matrix, it keeps its row when the receiver stalls and
//   the whole chain freezes until its last row is taken; req_tready then drops.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_core #(
   parameter int FRAC_BITS     = 16,
   parameter int AXIS_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // axis_x [15:0], axis_y [31:16], axis_z [47:32], angle [63:48]
   input  logic [63:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // elem0 [17:0], elem1 [35:18], elem2 [53:36], elem3 [71:54]
   output logic [71:0] rsp_tdata,
   // row_index [1:0], degenerate [2]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   localparam int CW  = aarm_pkg::CORD_W;
   localparam int EW  = aarm_pkg::ELEM_W;
   localparam int NW  = aarm_pkg::NMAG_W;
   localparam int NS  = aarm_pkg::SQRT_CELLS;
   localparam int ND  = aarm_pkg::DIV_CELLS;
   localparam int CSIDE_W = 49;
   localparam int SSIDE_W = 3 * NW + 4 + 2 * CW;
   localparam int DSIDE_W = 4 + 2 * CW;
   localparam int OUT_SH  = aarm_pkg::QBITS - FRAC_BITS;
   localparam logic signed [37:0] OUT_HALF = 38'sd1 <<< (OUT_SH - 1);
   localparam logic signed [37:0] OUT_ONE  = 38'sd1 <<< FRAC_BITS;
   localparam logic [EW-1:0]      ONE_OUT  = OUT_ONE[EW-1:0];
   localparam logic signed [34:0] QONE     = 35'sd1 <<< aarm_pkg::QBITS;
   localparam logic [1:0]         ROW_LAST = 2'd3;

   logic adv;
   aarm_pkg::aarm_step_type st;

   // ---------------- input register ----------------
   logic        s0_vld_ff;
   logic [63:0] s0_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_data_ff <= req_tdata;
      end
   end

   // ---------------- CORDIC chain ----------------
   logic              cor_vld  [CORDIC_STAGES+1];
   logic signed [CW-1:0] cor_x [CORDIC_STAGES+1];
   logic signed [CW-1:0] cor_y [CORDIC_STAGES+1];
   logic signed [CW-1:0] cor_z [CORDIC_STAGES+1];
   logic [CSIDE_W-1:0]   cor_side [CORDIC_STAGES+1];
   logic [31:0]          turn, turn_f;
   logic                 flip;

   // fold second and third quadrants by half a turn
   always_comb begin
      turn   = {s0_data_ff[63:48], 16'd0};
      flip   = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
      turn_f = flip ? (turn ^ 32'h8000_0000) : turn;
   end

   assign st          = '{en: adv, vld: 1'b0};
   assign cor_vld[0]  = s0_vld_ff;
   assign cor_x[0]    = aarm_pkg::CORDIC_K;
   assign cor_y[0]    = '0;
   assign cor_z[0]    = CW'($signed(turn_f));
   assign cor_side[0] = {flip, s0_data_ff[47:0]};

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      aarm_cordic_cell #(.STAGE(g), .SIDE_W(CSIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      ('{en: st.en, vld: cor_vld[g]}),
         .prev_x    (cor_x[g]),
         .prev_y    (cor_y[g]),
         .prev_z    (cor_z[g]),
         .prev_side (cor_side[g]),
         .out_vld   (cor_vld[g+1]),
         .out_x     (cor_x[g+1]),
         .out_y     (cor_y[g+1]),
         .out_z     (cor_z[g+1]),
         .out_side  (cor_side[g+1])
      );
   end

   // ---------------- stage a: sign, magnitude, maximum ----------------
   logic                 a_vld_ff, a_degen_ff;
   logic [2:0][31:0]     a_mag_ff, a_mag_in;
   logic [2:0]           a_sgn_ff, a_sgn_in;
   logic [31:0]          a_mx_ff, a_mx_in;
   logic signed [CW-1:0] a_sn_ff, a_cs_ff, a_sn_in, a_cs_in;
   logic [31:0]          raw;

   always_comb begin
      a_mx_in = '0;
      raw     = '0;
      for (int i = 0; i < 3; i++) begin
         raw         = {16'd0, cor_side[CORDIC_STAGES][16*i +: 16]};
         a_sgn_in[i] = raw[AXIS_WIDTH-1];
         if (a_sgn_in[i]) begin
            a_mag_in[i] = 32'((33'd1 << AXIS_WIDTH) - 33'(raw[AXIS_WIDTH-1:0]));
         end else begin
            a_mag_in[i] = 32'(raw[AXIS_WIDTH-1:0]);
         end
         if (a_mag_in[i] > a_mx_in) begin
            a_mx_in = a_mag_in[i];
         end
      end
      if (cor_side[CORDIC_STAGES][48]) begin
         a_cs_in = -cor_x[CORDIC_STAGES];
         a_sn_in = -cor_y[CORDIC_STAGES];
      end else begin
         a_cs_in = cor_x[CORDIC_STAGES];
         a_sn_in = cor_y[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= cor_vld[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff   <= a_mag_in;
         a_sgn_ff   <= a_sgn_in;
         a_mx_ff    <= a_mx_in;
         a_degen_ff <= (a_mx_in == 32'd0);
         a_sn_ff    <= a_sn_in;
         a_cs_ff    <= a_cs_in;
      end
   end

   // ---------------- stage b: common left shift ----------------
   logic                 b_vld_ff, b_degen_ff;
   logic [2:0][NW-1:0]   b_mag_ff, b_mag_in;
   logic [2:0]           b_sgn_ff;
   logic signed [CW-1:0] b_sn_ff, b_cs_ff;
   logic [31:0]          sh_mx;
   logic [4:0]           sh_amt;

   // shift the largest magnitude into [2^29, 2^30)
   always_comb begin
      sh_mx  = a_mx_ff;
      sh_amt = '0;
      for (int k = 4; k >= 0; k--) begin
         if (sh_mx < (32'd1 << (30 - (1 << k)))) begin
            sh_mx  = sh_mx << (1 << k);
            sh_amt = sh_amt + 5'(1 << k);
         end
      end
      for (int i = 0; i < 3; i++) begin
         b_mag_in[i] = NW'(a_mag_ff[i] << sh_amt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_mag_ff   <= b_mag_in;
         b_sgn_ff   <= a_sgn_ff;
         b_degen_ff <= a_degen_ff;
         b_sn_ff    <= a_sn_ff;
         b_cs_ff    <= a_cs_ff;
      end
   end

   // ---------------- stage c: squares ----------------
   logic                 c_vld_ff, c_degen_ff;
   logic [2:0][59:0]     c_sq_ff;
   logic [2:0][NW-1:0]   c_mag_ff;
   logic [2:0]           c_sgn_ff;
   logic signed [CW-1:0] c_sn_ff, c_cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            c_sq_ff[i] <= 60'(b_mag_ff[i]) * 60'(b_mag_ff[i]);
         end
         c_mag_ff   <= b_mag_ff;
         c_sgn_ff   <= b_sgn_ff;
         c_degen_ff <= b_degen_ff;
         c_sn_ff    <= b_sn_ff;
         c_cs_ff    <= b_cs_ff;
      end
   end

   // ---------------- stage d: sum of squares ----------------
   logic                        d_vld_ff;
   logic [aarm_pkg::ROOT_W-1:0] d_sum_ff;
   logic [SSIDE_W-1:0]          d_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_sum_ff  <= aarm_pkg::ROOT_W'(c_sq_ff[0]) + aarm_pkg::ROOT_W'(c_sq_ff[1])
                    + aarm_pkg::ROOT_W'(c_sq_ff[2]);
         d_side_ff <= {c_cs_ff, c_sn_ff, c_degen_ff, c_sgn_ff, c_mag_ff};
      end
   end

   // ---------------- square root chain ----------------
   logic                        sq_vld  [NS+1];
   logic [aarm_pkg::ROOT_W-1:0] sq_rem  [NS+1];
   logic [aarm_pkg::ROOT_W-1:0] sq_root [NS+1];
   logic [SSIDE_W-1:0]          sq_side [NS+1];

   assign sq_vld[0]  = d_vld_ff;
   assign sq_rem[0]  = d_sum_ff;
   assign sq_root[0] = '0;
   assign sq_side[0] = d_side_ff;

   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      aarm_sqrt_cell #(.STAGE(g), .SIDE_W(SSIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      ('{en: st.en, vld: sq_vld[g]}),
         .prev_rem  (sq_rem[g]),
         .prev_root (sq_root[g]),
         .prev_side (sq_side[g]),
         .out_vld   (sq_vld[g+1]),
         .out_rem   (sq_rem[g+1]),
         .out_root  (sq_root[g+1]),
         .out_side  (sq_side[g+1])
      );
   end

   // ---------------- stage e: dividend with rounding ----------------
   logic                                e_vld_ff;
   logic [2:0][aarm_pkg::NUM_W-1:0]     e_num_ff, e_num_in;
   logic [aarm_pkg::DVS_W-1:0]          e_dvs_ff, e_dvs_in;
   logic [DSIDE_W-1:0]                  e_side_ff;
   logic [SSIDE_W-1:0]                  sq_out;

   always_comb begin
      sq_out   = sq_side[NS];
      e_dvs_in = sq_root[NS][aarm_pkg::DVS_W-1:0];
      for (int i = 0; i < 3; i++) begin
         e_num_in[i] = aarm_pkg::NUM_W'({sq_out[NW*i +: NW], 30'd0})
                     + aarm_pkg::NUM_W'(e_dvs_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= sq_vld[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_num_ff  <= e_num_in;
         e_dvs_ff  <= e_dvs_in;
         e_side_ff <= sq_out[SSIDE_W-1:3*NW];
      end
   end

   // ---------------- divider chain ----------------
   logic                             dv_vld  [ND+1];
   logic [2:0][aarm_pkg::NUM_W-1:0]  dv_rem  [ND+1];
   logic [2:0][aarm_pkg::DVS_W-1:0]  dv_quo  [ND+1];
   logic [aarm_pkg::DVS_W-1:0]       dv_dvs  [ND+1];
   logic [DSIDE_W-1:0]               dv_side [ND+1];

   assign dv_vld[0]  = e_vld_ff;
   assign dv_rem[0]  = e_num_ff;
   assign dv_quo[0]  = '0;
   assign dv_dvs[0]  = e_dvs_ff;
   assign dv_side[0] = e_side_ff;

   for (genvar g = 0; g < ND; g++) begin : g_div
      aarm_div_cell #(.STAGE(g), .SIDE_W(DSIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      ('{en: st.en, vld: dv_vld[g]}),
         .prev_rem  (dv_rem[g]),
         .prev_quo  (dv_quo[g]),
         .prev_dvs  (dv_dvs[g]),
         .prev_side (dv_side[g]),
         .out_vld   (dv_vld[g+1]),
         .out_rem   (dv_rem[g+1]),
         .out_quo   (dv_quo[g+1]),
         .out_dvs   (dv_dvs[g+1]),
         .out_side  (dv_side[g+1])
      );
   end

   // ---------------- stage f: signed unit vector, 1 - cos ----------------
   logic                      f_vld_ff, f_degen_ff;
   logic signed [31:0]        f_u_ff [3];
   logic signed [31:0]        f_u_in [3];
   logic signed [34:0]        f_ci_ff, f_ci_in;
   logic signed [CW-1:0]      f_sn_ff, f_cs_ff, f_sn_in, f_cs_in;
   logic [DSIDE_W-1:0]        dv_out;

   always_comb begin
      dv_out  = dv_side[ND];
      f_sn_in = dv_out[4 +: CW];
      f_cs_in = dv_out[4+CW +: CW];
      f_ci_in = QONE - f_cs_in;
      for (int i = 0; i < 3; i++) begin
         if (dv_out[i]) begin
            f_u_in[i] = -$signed({1'b0, dv_quo[ND][i]});
         end else begin
            f_u_in[i] = $signed({1'b0, dv_quo[ND][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= dv_vld[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_u_ff     <= f_u_in;
         f_ci_ff    <= f_ci_in;
         f_sn_ff    <= f_sn_in;
         f_cs_ff    <= f_cs_in;
         f_degen_ff <= dv_out[3];
      end
   end

   // ---------------- stage g: pair products and sine terms ----------------
   // pair order: xx, xy, xz, yy, yz, zz
   logic                 g_vld_ff, g_degen_ff;
   logic signed [63:0]   g_pp_ff [6];
   logic signed [65:0]   g_us_ff [3];
   logic signed [34:0]   g_ci_ff;
   logic signed [CW-1:0] g_cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_pp_ff[0] <= f_u_ff[0] * f_u_ff[0];
         g_pp_ff[1] <= f_u_ff[0] * f_u_ff[1];
         g_pp_ff[2] <= f_u_ff[0] * f_u_ff[2];
         g_pp_ff[3] <= f_u_ff[1] * f_u_ff[1];
         g_pp_ff[4] <= f_u_ff[1] * f_u_ff[2];
         g_pp_ff[5] <= f_u_ff[2] * f_u_ff[2];
         for (int i = 0; i < 3; i++) begin
            g_us_ff[i] <= f_u_ff[i] * f_sn_ff;
         end
         g_ci_ff    <= f_ci_ff;
         g_cs_ff    <= f_cs_ff;
         g_degen_ff <= f_degen_ff;
      end
   end

   // ---------------- stage h: round pairs, scale by 1 - cos ----------------
   logic                 h_vld_ff, h_degen_ff;
   logic signed [68:0]   h_pc_ff [6];
   logic signed [68:0]   h_pc_in [6];
   logic signed [35:0]   h_us_ff [3];
   logic signed [35:0]   h_us_in [3];
   logic signed [CW-1:0] h_cs_ff;
   logic signed [63:0]   pp_rnd;
   logic signed [33:0]   pp_q;
   logic signed [65:0]   us_rnd;

   always_comb begin
      pp_rnd = '0;
      pp_q   = '0;
      us_rnd = '0;
      for (int k = 0; k < 6; k++) begin
         pp_rnd     = (g_pp_ff[k] + 64'sd536870912) >>> aarm_pkg::QBITS;
         pp_q       = pp_rnd[33:0];
         h_pc_in[k] = pp_q * g_ci_ff;
      end
      for (int i = 0; i < 3; i++) begin
         us_rnd     = (g_us_ff[i] + 66'sd536870912) >>> aarm_pkg::QBITS;
         h_us_in[i] = us_rnd[35:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_pc_ff    <= h_pc_in;
         h_us_ff    <= h_us_in;
         h_cs_ff    <= g_cs_ff;
         h_degen_ff <= g_degen_ff;
      end
   end

   // ---------------- stage i: matrix elements in Q2.30 ----------------
   logic                 i_vld_ff, i_degen_ff;
   logic signed [37:0]   i_m_ff [9];
   logic signed [37:0]   i_m_in [9];
   logic signed [37:0]   pc [6];
   logic signed [68:0]   pc_rnd;

   always_comb begin
      pc_rnd = '0;
      for (int k = 0; k < 6; k++) begin
         pc_rnd = (h_pc_ff[k] + 69'sd536870912) >>> aarm_pkg::QBITS;
         pc[k]  = pc_rnd[37:0];
      end
      i_m_in[0] = h_cs_ff + pc[0];
      i_m_in[1] = pc[1] - h_us_ff[2];
      i_m_in[2] = pc[2] + h_us_ff[1];
      i_m_in[3] = pc[1] + h_us_ff[2];
      i_m_in[4] = h_cs_ff + pc[3];
      i_m_in[5] = pc[4] - h_us_ff[0];
      i_m_in[6] = pc[2] - h_us_ff[1];
      i_m_in[7] = pc[4] + h_us_ff[0];
      i_m_in[8] = h_cs_ff + pc[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i_m_ff     <= i_m_in;
         i_degen_ff <= h_degen_ff;
      end
   end

   // ---------------- stage j: round, saturate, identity on zero axis ------
   logic                 j_vld_ff, j_degen_ff;
   logic [8:0][EW-1:0]   j_elem_ff, j_elem_in;
   logic signed [37:0]   r_el;

   always_comb begin
      r_el = '0;
      for (int k = 0; k < 9; k++) begin
         r_el = (i_m_ff[k] + OUT_HALF) >>> OUT_SH;
         if (r_el > OUT_ONE) begin
            r_el = OUT_ONE;
         end
         if (r_el < -OUT_ONE) begin
            r_el = -OUT_ONE;
         end
         if (i_degen_ff) begin
            j_elem_in[k] = (k % 4 == 0) ? ONE_OUT : '0;
         end else begin
            j_elem_in[k] = r_el[EW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else if (adv) begin
         j_vld_ff <= i_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         j_elem_ff  <= j_elem_in;
         j_degen_ff <= i_degen_ff;
      end
   end

   // ---------------- output register and row sequencing ----------------
   logic               busy_ff, busy_in;
   logic [1:0]         row_ff, row_in;
   logic [8:0][EW-1:0] ob_elem_ff;
   logic               ob_degen_ff;
   logic               rsp_xfer;
   logic [EW-1:0]      e0, e1, e2, e3;

   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign adv        = !busy_ff || (rsp_tready && row_ff == ROW_LAST);
   assign req_tready = adv;

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      if (rsp_xfer) begin
         row_in = row_ff + 2'd1;
         if (row_ff == ROW_LAST) begin
            busy_in = 1'b0;
         end
      end
      if (adv && j_vld_ff) begin
         busy_in = 1'b1;
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && j_vld_ff) begin
         ob_elem_ff  <= j_elem_ff;
         ob_degen_ff <= j_degen_ff;
      end
   end

   // row select
   always_comb begin
      case (row_ff)
         2'd0: begin
            e0 = ob_elem_ff[0]; e1 = ob_elem_ff[1]; e2 = ob_elem_ff[2]; e3 = '0;
         end
         2'd1: begin
            e0 = ob_elem_ff[3]; e1 = ob_elem_ff[4]; e2 = ob_elem_ff[5]; e3 = '0;
         end
         2'd2: begin
            e0 = ob_elem_ff[6]; e1 = ob_elem_ff[7]; e2 = ob_elem_ff[8]; e3 = '0;
         end
         default: begin
            e0 = '0; e1 = '0; e2 = '0; e3 = ONE_OUT;
         end
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {e3, e2, e1, e0};
   assign rsp_tuser  = {ob_degen_ff, row_ff};
   assign rsp_tlast  = (row_ff == ROW_LAST);

   // ---------------- assertions ----------------
   // rows of one matrix follow in order without a gap in numbering
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_tlast) |=> (rsp_tvalid && rsp_tuser[1:0] == $past(rsp_tuser[1:0]) + 2'd1))
      else $error("row index did not advance by one");

   // degenerate flag is the same on every row of a matrix
   a_degen_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_tlast) |=> (rsp_tuser[2] == $past(rsp_tuser[2])))
      else $error("degenerate flag changed within a matrix");

   // a zero axis gives the identity on its first row
   a_degen_ident: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2] && rsp_tuser[1:0] == 2'd0) |->
      (rsp_tdata[17:0] == ONE_OUT && rsp_tdata[35:18] == '0 && rsp_tdata[53:36] == '0))
      else $error("zero axis did not produce identity");

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented after reset");

endmodule

// ----- sv/aarm_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// aarm_cordic_cell
// One rotation-mode CORDIC micro-rotation; passes side data along unchanged.
// ---------------------------------------------------------------------------
module aarm_cordic_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  aarm_pkg::aarm_step_type                 step,
   input  logic signed [aarm_pkg::CORD_W-1:0]      prev_x,
   input  logic signed [aarm_pkg::CORD_W-1:0]      prev_y,
   input  logic signed [aarm_pkg::CORD_W-1:0]      prev_z,
   input  logic        [SIDE_W-1:0]                prev_side,
   output logic                                    out_vld,
   output logic signed [aarm_pkg::CORD_W-1:0]      out_x,
   output logic signed [aarm_pkg::CORD_W-1:0]      out_y,
   output logic signed [aarm_pkg::CORD_W-1:0]      out_z,
   output logic        [SIDE_W-1:0]                out_side
);

   localparam logic signed [aarm_pkg::CORD_W-1:0] ATAN =
      $signed({{(aarm_pkg::CORD_W-32){1'b0}}, aarm_pkg::ATAN_TURN[STAGE]});

   logic                                 vld_ff;
   logic signed [aarm_pkg::CORD_W-1:0]   x_ff, y_ff, z_ff;
   logic signed [aarm_pkg::CORD_W-1:0]   x_in, y_in, z_in;
   logic signed [aarm_pkg::CORD_W-1:0]   dx, dy;
   logic        [SIDE_W-1:0]             side_ff;

   // rotate toward zero residual angle
   always_comb begin
      dx = prev_y >>> STAGE;
      dy = prev_x >>> STAGE;
      if (!prev_z[aarm_pkg::CORD_W-1]) begin
         x_in = prev_x - dx;
         y_in = prev_y + dy;
         z_in = prev_z - ATAN;
      end else begin
         x_in = prev_x + dx;
         y_in = prev_y - dy;
         z_in = prev_z + ATAN;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (step.en) begin
         vld_ff <= step.vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (step.en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= prev_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_side = side_ff;

endmodule

// ----- sv/aarm_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// aarm_sqrt_cell
// One digit step of the bitwise integer square root; side data rides along.
// ---------------------------------------------------------------------------
module aarm_sqrt_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  aarm_pkg::aarm_step_type          step,
   input  logic [aarm_pkg::ROOT_W-1:0]      prev_rem,
   input  logic [aarm_pkg::ROOT_W-1:0]      prev_root,
   input  logic [SIDE_W-1:0]                prev_side,
   output logic                             out_vld,
   output logic [aarm_pkg::ROOT_W-1:0]      out_rem,
   output logic [aarm_pkg::ROOT_W-1:0]      out_root,
   output logic [SIDE_W-1:0]                out_side
);

   localparam logic [aarm_pkg::ROOT_W-1:0] BIT =
      aarm_pkg::ROOT_W'(1) << (62 - 2 * STAGE);

   logic                            vld_ff;
   logic [aarm_pkg::ROOT_W-1:0]     rem_ff, root_ff, rem_in, root_in, trial;
   logic [SIDE_W-1:0]               side_ff;

   // try to set this root bit
   always_comb begin
      trial = prev_root + BIT;
      if (prev_rem >= trial) begin
         rem_in  = prev_rem - trial;
         root_in = (prev_root >> 1) + BIT;
      end else begin
         rem_in  = prev_rem;
         root_in = prev_root >> 1;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (step.en) begin
         vld_ff <= step.vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (step.en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= prev_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;
   assign out_side = side_ff;

endmodule

// ----- sv/aarm_div_cell.sv -----
// ---------------------------------------------------------------------------
// aarm_div_cell
// One restoring division step for the three axis lanes sharing a divisor.
// ---------------------------------------------------------------------------
module aarm_div_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  aarm_pkg::aarm_step_type                step,
   input  logic [2:0][aarm_pkg::NUM_W-1:0]        prev_rem,
   input  logic [2:0][aarm_pkg::DVS_W-1:0]        prev_quo,
   input  logic [aarm_pkg::DVS_W-1:0]             prev_dvs,
   input  logic [SIDE_W-1:0]                      prev_side,
   output logic                                   out_vld,
   output logic [2:0][aarm_pkg::NUM_W-1:0]        out_rem,
   output logic [2:0][aarm_pkg::DVS_W-1:0]        out_quo,
   output logic [aarm_pkg::DVS_W-1:0]             out_dvs,
   output logic [SIDE_W-1:0]                      out_side
);

   localparam int SHIFT = aarm_pkg::DVS_W - 1 - STAGE;

   logic                                  vld_ff;
   logic [2:0][aarm_pkg::NUM_W-1:0]       rem_ff, rem_in;
   logic [2:0][aarm_pkg::DVS_W-1:0]       quo_ff, quo_in;
   logic [aarm_pkg::DVS_W-1:0]            dvs_ff;
   logic [aarm_pkg::NUM_W-1:0]            trial;
   logic [SIDE_W-1:0]                     side_ff;

   // compare and subtract the shifted divisor in each lane
   always_comb begin
      trial = aarm_pkg::NUM_W'(prev_dvs) << SHIFT;
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = prev_rem[i];
         quo_in[i] = prev_quo[i];
         if (prev_rem[i] >= trial) begin
            rem_in[i]        = prev_rem[i] - trial;
            quo_in[i][SHIFT] = 1'b1;
         end
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (step.en) begin
         vld_ff <= step.vld;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (step.en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dvs_ff  <= prev_dvs;
         side_ff <= prev_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rem  = rem_ff;
   assign out_quo  = quo_ff;
   assign out_dvs  = dvs_ff;
   assign out_side = side_ff;

endmodule

// ----- test/axis_angle_rotation_matrix_checker.sv -----
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_checker
// Watches both streams of the rotation matrix core, computes the four rows
// each accepted request should give and compares them in order.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] req_tdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   output int          fail_count,
   output int          rows_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FRAC  = 16;
   localparam longint QONE  = 64'sd1 << aarm_pkg::QBITS;

   // one expected row: tdata, tuser and tlast together
   typedef struct packed {
      logic [71:0] data;
      logic [2:0]  user;
      logic        last;
   } row_t;

   row_t row_queue[$];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_shift(a * b, aarm_pkg::QBITS);
   endfunction

   // element to Q2.16 with saturation
   function automatic logic [17:0] to_elem(longint v);
      longint r;
      longint one;
      one = 64'sd1 <<< FRAC;
      r = round_shift(v, aarm_pkg::QBITS - FRAC);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[17:0];
   endfunction

   function automatic longint int_sqrt(longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // rotation-mode sine and cosine in Q2.30
   task automatic sin_cos(input logic [15:0] ang, output longint sn, output longint cs);
      logic [31:0] t;
      logic        flip;
      longint      x, y, z, dx, dy;
      t = {ang, 16'd0};
      flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
      if (flip) t = t + 32'h8000_0000;
      z = longint'($signed(t));
      x = aarm_pkg::CORDIC_K;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(aarm_pkg::ATAN_TURN[i]);
         end else begin
            x += dx; y -= dy; z += longint'(aarm_pkg::ATAN_TURN[i]);
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   // four expected rows of one request
   task automatic predict_matrix(input logic [63:0] req);
      longint          a[3], u[3], m[3][3];
      longint unsigned mag[3], mx, sum, n, q;
      longint          sn, cs, ci;
      logic            degen;
      row_t            r;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'($signed(req[16*i +: 16]));
         mag[i] = (a[i] < 0) ? -a[i] : a[i];
         if (mag[i] > mx) mx = mag[i];
      end
      degen = (mx == 0);
      if (degen) begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? QONE : 0;
      end else begin
         while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
         end
         sum = 0;
         for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
         n = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 30) + (n >> 1)) / n;
            u[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
         end
         sin_cos(req[63:48], sn, cs);
         ci = QONE - cs;
         m[0][0] = cs + qmul(qmul(u[0], u[0]), ci);
         m[0][1] = qmul(qmul(u[0], u[1]), ci) - qmul(u[2], sn);
         m[0][2] = qmul(qmul(u[0], u[2]), ci) + qmul(u[1], sn);
         m[1][0] = qmul(qmul(u[1], u[0]), ci) + qmul(u[2], sn);
         m[1][1] = cs + qmul(qmul(u[1], u[1]), ci);
         m[1][2] = qmul(qmul(u[1], u[2]), ci) - qmul(u[0], sn);
         m[2][0] = qmul(qmul(u[2], u[0]), ci) - qmul(u[1], sn);
         m[2][1] = qmul(qmul(u[2], u[1]), ci) + qmul(u[0], sn);
         m[2][2] = cs + qmul(qmul(u[2], u[2]), ci);
      end
      for (int i = 0; i < 4; i++) begin
         if (i < 3)
            r.data = {18'd0, to_elem(m[i][2]), to_elem(m[i][1]), to_elem(m[i][0])};
         else
            r.data = {18'd65536, 18'd0, 18'd0, 18'd0};
         r.user = {degen, 2'(i)};
         r.last = (i == 3);
         row_queue.push_back(r);
      end
   endtask

   // predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      row_t exp_row;
      if (reset) begin
         fail_count   <= 0;
         rows_pending <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_matrix(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (row_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected row: data=%h user=%h last=%b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               exp_row = row_queue.pop_front();
               if (exp_row.data !== rsp_tdata || exp_row.user !== rsp_tuser ||
                   exp_row.last !== rsp_tlast) begin
                  if (fail_count < 10)
                     $display("row mismatch: exp data=%h user=%h last=%b, got %h %h %b",
                              exp_row.data, exp_row.user, exp_row.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // rows still owed by the core
         rows_pending <= row_queue.size();
      end
   end

endmodule

// ----- test/axis_angle_rotation_matrix_core_tb.sv -----
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix_core_tb
// Drives directed and random axis-angle requests with bursty sending and a
// stalling receiver; the checker predicts and compares every matrix row.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQS = 220;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [63:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   int          fail_count;
   int          rows_pending;
   int          cycle_count = 0;

   always #5 clock = ~clock;

   axis_angle_rotation_matrix_core dut (.*);

   axis_angle_rotation_matrix_checker chk (.*);

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver stall pattern: runs of ready and stall of random length
   initial begin
      int run;
      @(negedge clock);
      forever begin
         run = $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(negedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // hold one request until it is taken; random gap before it
   task automatic send_request(input logic [63:0] req, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= req;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 4))
         0: return 16'($urandom_range(0, 7)) - 16'd3;
         1: return 16'h8000;
         2: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [63:0] directed [$];
      int burst;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, zero axis, quadrant boundaries of the angle
      directed = '{
         {16'h0000, 16'h0000, 16'h0000, 16'h0000},
         {16'h4000, 16'h0000, 16'h0000, 16'h7FFF},
         {16'h8000, 16'h0000, 16'h0000, 16'h8000},
         {16'hC000, 16'h0000, 16'h0000, 16'hFFFF},
         {16'h0000, 16'h0000, 16'h0001, 16'h0000},
         {16'h2000, 16'h0000, 16'h0000, 16'h0001},
         {16'hA000, 16'h0000, 16'h0001, 16'h0000},
         {16'h8000, 16'h8000, 16'h8000, 16'h8000},
         {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
         {16'h4001, 16'hFFFF, 16'h0000, 16'h0000},
         {16'h3FFF, 16'h0001, 16'hFFFF, 16'h8000},
         {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
         {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555},
         {16'h1234, 16'h0003, 16'hFFFD, 16'h0007},
         {16'hE000, 16'h0000, 16'h0000, 16'h0000},
         {16'h6000, 16'h0001, 16'h0001, 16'h0000}
      };
      foreach (directed[i]) send_request(directed[i], 0);

      // let everything drain before the random part
      req_tvalid <= 1'b0;
      while (rows_pending != 0) @(negedge clock);

      // random bursts with random gaps
      for (int n = 0; n < RANDOM_REQS; ) begin
         burst = $urandom_range(1, 10);
         for (int k = 0; k < burst && n < RANDOM_REQS; k++, n++)
            send_request({16'($urandom), rand_axis(), rand_axis(), rand_axis()},
                         (k == 0) ? $urandom_range(0, 15) : 0);
      end
      req_tvalid <= 1'b0;

      while (rows_pending != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/aarm_pkg.sv
sv/aarm_cordic_cell.sv
sv/aarm_sqrt_cell.sv
sv/aarm_div_cell.sv
sv/axis_angle_rotation_matrix_core.sv
test/axis_angle_rotation_matrix_checker.sv
test/axis_angle_rotation_matrix_core_tb.sv
